// ===== rtl/core/brf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring fifo: word layouts, the
// command and status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_MAX_READ    = 64;
    localparam int POS_SPAN        = 1024;

    localparam int CAP_W   = 11;
    localparam int USE_W   = 10;
    localparam int LIM_W   = 7;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [CAP_W-1:0] CAP_MIN   = 11'd2;

    localparam int FQ_DEPTH = 2;
    localparam int RQ_DEPTH = 4;
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic REG_CAPACITY = 1'b0;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] ST_WR_OK    = 2'd0;
    localparam logic [1:0] ST_WR_FULL  = 2'd1;
    localparam logic [1:0] ST_RD_BYTE  = 2'd2;
    localparam logic [1:0] ST_RD_EMPTY = 2'd3;

    typedef struct packed {
        logic             command;
        logic [7:0]       write_byte;
        logic [LIM_W-1:0] read_limit;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       read_byte;
        logic             last;
        logic [USE_W-1:0] usage;
    } t_out_word;

    typedef struct packed {
        logic             command;
        logic [7:0]       data;
        logic [LIM_W-1:0] limit;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_chan;

    typedef struct packed {
        logic      valid;
        logic      is_read;
        t_out_word word;
    } t_res_chan;

endpackage
`default_nettype wire

// ===== rtl/core/byte_ring_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte ring fifo with a programmable capacity that keeps one slot empty.
//
// Input words enter on push/full: a write word appends one byte, a read
// word asks for up to read_limit bytes. Result words leave on empty/pop,
// oldest first; each carries a status, the byte read, a last flag and the
// usage after it. A write gives one result, a read gives one result per
// byte taken out (one empty status if nothing can be taken).
// A word passes the input queue, the engine's result register and the result
// queue before its first result is on the ports. The engine issues one result
// per cycle while the result queue has room, so writes run at one word per
// cycle and a read of n bytes holds it for n results (single store read port).
// A two-word input queue and a four-word result queue decouple the sides:
// input is taken while results wait, and a stalled pop simply backs the
// engine up until a result entry frees.
// Reset empties both queues, zeroes the positions and sets the capacity
// to 1024; store contents are not cleared. Writing the capacity register
// (address 0) empties the fifo; pready is always high.
// ----------------------------------------------------------------------------
module byte_ring_fifo #(
    parameter int STORE_DEPTH = brf_pkg::DEF_STORE_DEPTH,
    parameter int MAX_READ    = brf_pkg::DEF_MAX_READ
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire brf_pkg::t_in_word           i_word,
    output logic                             empty,
    input  wire logic                        pop,
    output brf_pkg::t_out_word               o_word,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [brf_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [brf_pkg::CFG_DW-1:0]  pwdata,
    output logic [brf_pkg::CFG_DW-1:0]       prdata,
    output logic                             pready
);
    import brf_pkg::*;

    localparam int SPAN = (STORE_DEPTH < POS_SPAN) ? STORE_DEPTH : POS_SPAN;

    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] cap_eff;
    logic             cfg_wr;
    t_op_chan         op;
    logic             take;
    t_res_chan        res;
    logic [RQ_CW-1:0] rq_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DW'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        if (r_cap < CAP_MIN) begin
            cap_eff = CAP_MIN;
        end else if (r_cap > CAP_W'(SPAN)) begin
            cap_eff = CAP_W'(SPAN);
        end else begin
            cap_eff = r_cap;
        end
    end

    brf_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_word  (i_word),
        .o_op    (op),
        .i_take  (take)
    );

    brf_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_READ    (MAX_READ)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (cap_eff),
        .i_clear    (cfg_wr),
        .i_op       (op),
        .o_take     (take),
        .i_rq_count (rq_count),
        .o_res      (res)
    );

    brf_result_queue u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_word  (o_word),
        .o_count (rq_count)
    );

    a_rq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> (rq_count < RQ_CW'(RQ_DEPTH)))
        else $error("result queue overrun");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> op.valid)
        else $error("engine took from an empty input queue");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && !res.is_read) |-> (res.word.read_byte == 8'd0
            && res.word.status != ST_RD_BYTE))
        else $error("non-read result carries read data");

endmodule
`default_nettype wire

// ===== rtl/core/brf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brf_front
// Input side: accepts words, clamps the read limit and holds them in a
// short queue until the engine takes them.
// ----------------------------------------------------------------------------
module brf_front #(
    parameter int MAX_READ = brf_pkg::DEF_MAX_READ
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire brf_pkg::t_in_word i_word,
    output brf_pkg::t_op_chan      o_op,
    input  wire logic              i_take
);
    import brf_pkg::*;

    localparam int FPW = $clog2(FQ_DEPTH);
    localparam int FCW = $clog2(FQ_DEPTH + 1);

    t_op              r_slot [FQ_DEPTH];
    logic [FPW-1:0]   r_head;
    logic [FCW-1:0]   r_cnt;
    logic [FPW-1:0]   n_head;
    logic [FCW-1:0]   n_cnt;
    logic [FPW-1:0]   tail;
    logic [FCW:0]     tail_sum;
    logic             accept;
    logic             take;
    t_op              op_in;

    assign o_full = (r_cnt == FCW'(FQ_DEPTH));
    assign accept = i_push && !o_full;
    assign take   = i_take && (r_cnt != '0);

    always_comb begin
        op_in.command = i_word.command;
        op_in.data    = i_word.write_byte;
        op_in.limit   = (i_word.read_limit > LIM_W'(MAX_READ)) ? LIM_W'(MAX_READ)
                                                              : i_word.read_limit;
    end

    always_comb begin
        tail_sum = (FCW+1)'(r_head) + (FCW+1)'(r_cnt);
        if (tail_sum >= (FCW+1)'(FQ_DEPTH)) begin
            tail_sum = tail_sum - (FCW+1)'(FQ_DEPTH);
        end
        tail = tail_sum[FPW-1:0];
    end

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        if (take) begin
            n_head = (r_head == FPW'(FQ_DEPTH - 1)) ? '0 : r_head + FPW'(1);
        end
        case ({accept, take})
            2'b10:   n_cnt = r_cnt + FCW'(1);
            2'b01:   n_cnt = r_cnt - FCW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[tail] <= op_in;
        end
    end

    assign o_op.valid = (r_cnt != '0);
    assign o_op.op    = r_slot[r_head];

endmodule
`default_nettype wire

// ===== rtl/core/brf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brf_back
// Engine: owns the byte store and the ring positions, carries out writes
// and streams read bytes, one result per cycle while the result queue
// has room.
// ----------------------------------------------------------------------------
module brf_back #(
    parameter int STORE_DEPTH = brf_pkg::DEF_STORE_DEPTH,
    parameter int MAX_READ    = brf_pkg::DEF_MAX_READ
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [brf_pkg::CAP_W-1:0]   i_cap,
    input  wire logic                        i_clear,
    input  wire brf_pkg::t_op_chan           i_op,
    output logic                             o_take,
    input  wire logic [brf_pkg::RQ_CW-1:0]   i_rq_count,
    output brf_pkg::t_res_chan               o_res
);
    import brf_pkg::*;

    localparam int SPAN = (STORE_DEPTH < POS_SPAN) ? STORE_DEPTH : POS_SPAN;
    localparam int PW   = $clog2(SPAN);
    localparam int LW   = $clog2(MAX_READ + 1);

    logic [7:0]       r_mem [SPAN];
    logic [7:0]       r_rd_data;
    logic [PW-1:0]    r_wr_pos, n_wr_pos;
    logic [PW-1:0]    r_rd_pos, n_rd_pos;
    logic [USE_W-1:0] r_usage,  n_usage;
    logic [LW-1:0]    r_rem,    n_rem;
    logic             r_p_valid, n_p_valid;
    logic             r_p_rd,    n_p_rd;
    t_out_word        r_p_word,  n_p_word;

    logic             mem_we;
    logic             mem_re;
    logic             can_issue;
    logic [RQ_CW:0]   fill;
    logic [LW-1:0]    cnt;
    logic             is_full;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] pos,
                                             input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] s;
        s = CAP_W'(pos) + CAP_W'(1);
        return (s == cap) ? '0 : s[PW-1:0];
    endfunction

    assign fill      = (RQ_CW+1)'(i_rq_count) + (RQ_CW+1)'(r_p_valid);
    assign can_issue = (fill < (RQ_CW+1)'(RQ_DEPTH));
    assign is_full   = ({1'b0, r_usage} == (i_cap - CAP_W'(1)));

    always_comb begin
        if (r_usage < USE_W'(i_op.op.limit)) begin
            cnt = r_usage[LW-1:0];
        end else begin
            cnt = i_op.op.limit[LW-1:0];
        end
    end

    always_comb begin
        n_wr_pos  = r_wr_pos;
        n_rd_pos  = r_rd_pos;
        n_usage   = r_usage;
        n_rem     = r_rem;
        n_p_valid = 1'b0;
        n_p_rd    = 1'b0;
        n_p_word  = '0;
        o_take    = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        if (can_issue) begin
            if (r_rem != '0) begin
                mem_re          = 1'b1;
                n_rd_pos        = f_next(r_rd_pos, i_cap);
                n_usage         = r_usage - USE_W'(1);
                n_rem           = r_rem - LW'(1);
                n_p_valid       = 1'b1;
                n_p_rd          = 1'b1;
                n_p_word.status = ST_RD_BYTE;
                n_p_word.last   = (r_rem == LW'(1));
            end else if (i_op.valid) begin
                o_take        = 1'b1;
                n_p_valid     = 1'b1;
                n_p_word.last = 1'b1;
                if (i_op.op.command == CMD_WRITE) begin
                    if (is_full) begin
                        n_p_word.status = ST_WR_FULL;
                    end else begin
                        mem_we          = 1'b1;
                        n_wr_pos        = f_next(r_wr_pos, i_cap);
                        n_usage         = r_usage + USE_W'(1);
                        n_p_word.status = ST_WR_OK;
                    end
                end else begin
                    if (cnt == '0) begin
                        n_p_word.status = ST_RD_EMPTY;
                    end else begin
                        mem_re          = 1'b1;
                        n_rd_pos        = f_next(r_rd_pos, i_cap);
                        n_usage         = r_usage - USE_W'(1);
                        n_rem           = cnt - LW'(1);
                        n_p_rd          = 1'b1;
                        n_p_word.status = ST_RD_BYTE;
                        n_p_word.last   = (cnt == LW'(1));
                    end
                end
            end
        end
        n_p_word.usage = n_usage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos  <= '0;
            r_rd_pos  <= '0;
            r_usage   <= '0;
            r_rem     <= '0;
            r_p_valid <= 1'b0;
        end else if (i_clear) begin
            r_wr_pos  <= '0;
            r_rd_pos  <= '0;
            r_usage   <= '0;
            r_rem     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_wr_pos  <= n_wr_pos;
            r_rd_pos  <= n_rd_pos;
            r_usage   <= n_usage;
            r_rem     <= n_rem;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_rd   <= n_p_rd;
        r_p_word <= n_p_word;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_pos] <= i_op.op.data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd_pos];
        end
    end

    always_comb begin
        o_res.valid          = r_p_valid;
        o_res.is_read        = r_p_rd;
        o_res.word           = r_p_word;
        o_res.word.read_byte = r_p_rd ? r_rd_data : 8'd0;
    end

endmodule
`default_nettype wire

// ===== rtl/core/brf_result_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brf_result_queue
// Small result queue between the engine and the output channel; the
// engine only issues while it holds a free entry.
// ----------------------------------------------------------------------------
module brf_result_queue (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire brf_pkg::t_res_chan        i_res,
    input  wire logic                      i_pop,
    output logic                           o_empty,
    output brf_pkg::t_out_word             o_word,
    output logic [brf_pkg::RQ_CW-1:0]      o_count
);
    import brf_pkg::*;

    localparam int RPW = $clog2(RQ_DEPTH);

    t_out_word        r_slot [RQ_DEPTH];
    logic [RPW-1:0]   r_head, r_tail;
    logic [RQ_CW-1:0] r_cnt;
    logic             pop_ok;

    assign o_empty = (r_cnt == '0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_word  = r_slot[r_head];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_res.valid) begin
                r_tail <= (r_tail == RPW'(RQ_DEPTH - 1)) ? '0 : r_tail + RPW'(1);
            end
            if (pop_ok) begin
                r_head <= (r_head == RPW'(RQ_DEPTH - 1)) ? '0 : r_head + RPW'(1);
            end
            case ({i_res.valid, pop_ok})
                2'b10:   r_cnt <= r_cnt + RQ_CW'(1);
                2'b01:   r_cnt <= r_cnt - RQ_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_slot[r_tail] <= i_res.word;
        end
    end

endmodule
`default_nettype wire
